/* hw/rtl/ring_fifo_with_peek_and_drop_assert.svh */
// ----------------------------------------------------------------------------
// Ring FIFO assertion macros
// Clocked assertion wrappers shared by the ring FIFO RTL.
// ----------------------------------------------------------------------------
`ifndef RING_FIFO_WITH_PEEK_AND_DROP_ASSERT_SVH
`define RING_FIFO_WITH_PEEK_AND_DROP_ASSERT_SVH

// check under reset gating
`define RFPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// check on every clock edge, reset included
`define RFPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/rfpd_pkg.sv */
// ----------------------------------------------------------------------------
// Ring FIFO package
// Sizes, operation and status codes for the ring FIFO with peek and drop.
// ----------------------------------------------------------------------------
package rfpd_pkg;

  localparam int Depth   = 16;
  localparam int DataW   = 32;
  localparam int SlotW   = $clog2(Depth);
  localparam int CountW  = $clog2(Depth + 1);
  localparam int OpW     = 2;
  localparam int StatusW = 2;
  localparam int ApbW    = 32;
  localparam int AddrW   = 3;

  localparam logic [CountW-1:0] CapReset = CountW'(Depth);

  typedef enum logic [OpW-1:0] {
    OpPut    = 2'd0,
    OpPick   = 2'd1,
    OpCopy   = 2'd2,
    OpDelete = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  localparam logic RegCapacity = 1'b0;

endpackage

/* hw/rtl/ring_fifo_with_peek_and_drop.sv */
// ----------------------------------------------------------------------------
// Ring FIFO with peek and drop
// Circular word queue with put, pick, copy and delete operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one operation word: op_i
//   selects put, pick, copy or delete, data_in_i is the word stored on put.
//   Output channel (out_valid_o/out_ready_i) returns one result word for
//   each operation: status, slot touched, data read and occupancy after it.
//   The operation is executed in its accept cycle and the result is
//   registered. One operation is taken every cycle unless the output stalls;
//   the single pass through the pointer, count and slot-register logic
//   sets that rate. When the receiver stalls the result register holds and
//   in_ready_o stays high only once the held result is taken that cycle.
//   Reset empties the queue, clears both pointers and sets capacity to the
//   full ring. The slot registers are not cleared; only held words are read.
//   The APB port holds the capacity register at address 0; writing it
//   empties the queue. Write it only while no operation is in flight.
// ----------------------------------------------------------------------------
`include "ring_fifo_with_peek_and_drop_assert.svh"

module ring_fifo_with_peek_and_drop (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [rfpd_pkg::AddrW-1:0]    paddr_i,
  input  logic [rfpd_pkg::ApbW-1:0]     pwdata_i,
  output logic [rfpd_pkg::ApbW-1:0]     prdata_o,
  output logic                          pready_o,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rfpd_pkg::OpW-1:0]      op_i,
  input  logic [rfpd_pkg::DataW-1:0]    data_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rfpd_pkg::StatusW-1:0]  status_o,
  output logic [rfpd_pkg::SlotW-1:0]    slot_o,
  output logic [rfpd_pkg::DataW-1:0]    data_out_o,
  output logic [rfpd_pkg::CountW-1:0]   occupancy_o
);
  import rfpd_pkg::*;

  logic [DataW-1:0]  slots_q [Depth];
  logic [SlotW-1:0]  wr_q, wr_d;
  logic [SlotW-1:0]  rd_q, rd_d;
  logic [CountW-1:0] held_q, held_d;
  logic [CountW-1:0] cap_q, cap_d;

  logic              out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [DataW-1:0]  dout_q, dout_d;
  logic [CountW-1:0] occ_q;

  logic              cfg_we;
  logic              in_fire;
  logic              slot_we;
  logic              full;
  logic              empty;
  logic [CountW-1:0] wdata_cap;
  op_e               op;

  function automatic logic [SlotW-1:0] advance(logic [SlotW-1:0] p, logic [CountW-1:0] cap);
    logic [CountW-1:0] nxt;
    nxt = CountW'(p) + CountW'(1);
    return (nxt >= cap) ? '0 : nxt[SlotW-1:0];
  endfunction

  assign pready_o    = 1'b1;
  assign prdata_o    = ApbW'(cap_q);
  assign cfg_we      = psel_i & penable_i & pwrite_i & (paddr_i[2] == RegCapacity);
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;
  assign op          = op_e'(op_i);
  assign full        = (held_q >= cap_q);
  assign empty       = (held_q == '0);

  always_comb begin
    wdata_cap = pwdata_i[CountW-1:0];
    if (wdata_cap == '0) begin
      wdata_cap = CountW'(1);
    end else if (wdata_cap > CountW'(Depth)) begin
      wdata_cap = CountW'(Depth);
    end
  end

  always_comb begin
    wr_d     = wr_q;
    rd_d     = rd_q;
    held_d   = held_q;
    cap_d    = cap_q;
    slot_we  = 1'b0;
    status_d = StDone;
    slot_d   = '0;
    dout_d   = '0;
    if (cfg_we) begin
      cap_d  = wdata_cap;
      wr_d   = '0;
      rd_d   = '0;
      held_d = '0;
    end else if (in_fire) begin
      case (op)
        OpPut: begin
          if (full) begin
            status_d = StFull;
          end else begin
            slot_we = 1'b1;
            slot_d  = wr_q;
            wr_d    = advance(wr_q, cap_q);
            held_d  = held_q + CountW'(1);
          end
        end
        OpPick, OpCopy, OpDelete: begin
          if (empty) begin
            status_d = StEmpty;
            wr_d     = '0;
            rd_d     = '0;
          end else begin
            slot_d = rd_q;
            if (op != OpDelete) begin
              dout_d = slots_q[rd_q];
            end
            if (op != OpCopy) begin
              held_d = held_q - CountW'(1);
              if (held_q == CountW'(1)) begin
                wr_d = '0;
                rd_d = '0;
              end else begin
                rd_d = advance(rd_q, cap_q);
              end
            end
          end
        end
        default: begin
          status_d = StDone;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      held_q      <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      held_q <= held_d;
      cap_q  <= cap_d;
      if (in_fire && !cfg_we) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slots_q[wr_q] <= data_in_i;
    end
    if (in_fire && !cfg_we) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      dout_q   <= dout_d;
      occ_q    <= held_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;
  assign data_out_o  = dout_q;
  assign occupancy_o = occ_q;

  `RFPD_ASSERT(a_held_le_cap, held_q <= cap_q, "occupancy above capacity")
  `RFPD_ASSERT(a_empty_ptrs, (held_q == '0) |-> (wr_q == '0 && rd_q == '0), "empty queue with pointers off slot zero")
  `RFPD_ASSERT(a_ptrs_in_ring, (CountW'(wr_q) < cap_q) && (CountW'(rd_q) < cap_q), "pointer outside ring")
  `RFPD_ASSERT(a_put_counts, (in_fire && !cfg_we && op == OpPut && !full) |=> (held_q == $past(held_q) + CountW'(1)), "put did not advance occupancy")
  `RFPD_ASSERT_ALWAYS(a_rdy_when_free, !out_valid_q |-> in_ready_o, "input stalled with empty result register")

endmodule

/* test/tb_ring_fifo_with_peek_and_drop.sv */
// ----------------------------------------------------------------------------
// Ring FIFO with peek and drop testbench
// Drives put, pick, copy and delete words through the valid/ready input
// channel. A scoreboard predicts each result word from its ring model or
// the directed table and compares it field by field with the output.
// The capacity register is rewritten over APB between phases, including
// the out-of-range values 0 and 31, while both channels idle and stall.
// ----------------------------------------------------------------------------
module tb_ring_fifo_with_peek_and_drop;
  import rfpd_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [SlotW-1:0]    slot;
    logic [DataW-1:0]    data;
    logic [CountW-1:0]   occ;
  } answer_t;

  typedef struct packed {
    logic                cfg_on;
    logic [CountW-1:0]   cfg_val;
    op_e                 op;
    logic [DataW-1:0]    data;
    logic                typed;
    answer_t             exp;
  } dir_row_t;

  localparam answer_t NoAns = '{StDone, 4'd0, 32'd0, 5'd0};
  localparam int DirRows = 24;
  localparam dir_row_t DirTab [DirRows] = '{
    '{1'b0, 5'd0,  OpCopy,   32'h0000_0000, 1'b1, '{StEmpty, 4'd0, 32'h0000_0000, 5'd0}},
    '{1'b0, 5'd0,  OpPick,   32'hFFFF_FFFF, 1'b1, '{StEmpty, 4'd0, 32'h0000_0000, 5'd0}},
    '{1'b0, 5'd0,  OpDelete, 32'h5555_5555, 1'b1, '{StEmpty, 4'd0, 32'h0000_0000, 5'd0}},
    '{1'b0, 5'd0,  OpPut,    32'hFFFF_FFFF, 1'b1, '{StDone,  4'd0, 32'h0000_0000, 5'd1}},
    '{1'b0, 5'd0,  OpPut,    32'h0000_0000, 1'b1, '{StDone,  4'd1, 32'h0000_0000, 5'd2}},
    '{1'b0, 5'd0,  OpCopy,   32'hAAAA_AAAA, 1'b1, '{StDone,  4'd0, 32'hFFFF_FFFF, 5'd2}},
    '{1'b0, 5'd0,  OpPick,   32'h0000_0000, 1'b1, '{StDone,  4'd0, 32'hFFFF_FFFF, 5'd1}},
    '{1'b0, 5'd0,  OpDelete, 32'h0000_0000, 1'b1, '{StDone,  4'd1, 32'h0000_0000, 5'd0}},
    '{1'b0, 5'd0,  OpPut,    32'hA5A5_A5A5, 1'b1, '{StDone,  4'd0, 32'h0000_0000, 5'd1}},
    '{1'b0, 5'd0,  OpPick,   32'h0000_0000, 1'b1, '{StDone,  4'd0, 32'hA5A5_A5A5, 5'd0}},
    '{1'b1, 5'd0,  OpPut,    32'h1234_5678, 1'b1, '{StDone,  4'd0, 32'h0000_0000, 5'd1}},
    '{1'b0, 5'd0,  OpPut,    32'h9ABC_DEF0, 1'b1, '{StFull,  4'd0, 32'h0000_0000, 5'd1}},
    '{1'b0, 5'd0,  OpCopy,   32'h0000_0000, 1'b1, '{StDone,  4'd0, 32'h1234_5678, 5'd1}},
    '{1'b0, 5'd0,  OpPick,   32'h0000_0000, 1'b1, '{StDone,  4'd0, 32'h1234_5678, 5'd0}},
    '{1'b0, 5'd0,  OpDelete, 32'h0000_0000, 1'b1, '{StEmpty, 4'd0, 32'h0000_0000, 5'd0}},
    '{1'b1, 5'd2,  OpPut,    32'h0000_0001, 1'b1, '{StDone,  4'd0, 32'h0000_0000, 5'd1}},
    '{1'b0, 5'd0,  OpPut,    32'h0000_0002, 1'b1, '{StDone,  4'd1, 32'h0000_0000, 5'd2}},
    '{1'b0, 5'd0,  OpPut,    32'h0000_0003, 1'b1, '{StFull,  4'd0, 32'h0000_0000, 5'd2}},
    '{1'b0, 5'd0,  OpPick,   32'h0000_0000, 1'b1, '{StDone,  4'd0, 32'h0000_0001, 5'd1}},
    '{1'b0, 5'd0,  OpPut,    32'h0000_0004, 1'b0, NoAns},
    '{1'b0, 5'd0,  OpPick,   32'h0000_0000, 1'b0, NoAns},
    '{1'b0, 5'd0,  OpPick,   32'hFFFF_FFFF, 1'b0, NoAns},
    '{1'b1, 5'd31, OpPut,    32'hDEAD_BEEF, 1'b1, '{StDone,  4'd0, 32'h0000_0000, 5'd1}},
    '{1'b0, 5'd0,  OpCopy,   32'h0000_0000, 1'b0, NoAns}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [ApbW-1:0]     pwdata;
  logic [ApbW-1:0]     prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  op_e                 in_op;
  logic [DataW-1:0]    in_data;
  logic                in_typed;
  answer_t             in_exp;
  logic                out_valid;
  logic                out_ready;
  logic [StatusW-1:0]  status;
  logic [SlotW-1:0]    slot;
  logic [DataW-1:0]    data_out;
  logic [CountW-1:0]   occupancy;

  logic [DataW-1:0]    ring_mem [Depth];
  logic [SlotW-1:0]    put_ptr;
  logic [SlotW-1:0]    take_ptr;
  logic [CountW-1:0]   held_words;
  logic [CountW-1:0]   cap_words;
  answer_t             answers_due [$];
  int                  mismatches = 0;
  bit                  tx_calm = 1'b0;
  bit                  rx_calm = 1'b0;

  ring_fifo_with_peek_and_drop dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_o    (prdata),
    .pready_o    (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (in_op),
    .data_in_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .slot_o      (slot),
    .data_out_o  (data_out),
    .occupancy_o (occupancy)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [SlotW-1:0] next_slot(logic [SlotW-1:0] p);
    return ({1'b0, p} + 5'd1 >= cap_words) ? '0 : p + 1'b1;
  endfunction

  function automatic void empty_ring();
    put_ptr    = '0;
    take_ptr   = '0;
    held_words = '0;
  endfunction

  function automatic answer_t ring_answer(op_e op, logic [DataW-1:0] word);
    answer_t r;
    r = NoAns;
    if (op == OpPut) begin
      if (held_words >= cap_words) begin
        r.status = StFull;
      end else begin
        ring_mem[put_ptr] = word;
        r.slot = put_ptr;
        put_ptr = next_slot(put_ptr);
        held_words = held_words + 1'b1;
      end
    end else if (held_words == 0) begin
      r.status = StEmpty;
      empty_ring();
    end else begin
      r.slot = take_ptr;
      if (op != OpDelete) r.data = ring_mem[take_ptr];
      if (op != OpCopy) begin
        held_words = held_words - 1'b1;
        if (held_words == 0) empty_ring();
        else take_ptr = next_slot(take_ptr);
      end
    end
    r.occ = held_words;
    return r;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: unexpected word: status %0d slot %0d data %h occ %0d",
                   $time, status, slot, data_out, occupancy);
          mismatches++;
        end else begin
          want = answers_due.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatches++;
          end
          if (slot !== want.slot) begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
            mismatches++;
          end
          if (data_out !== want.data) begin
            $display("%0t: data_out expected %h actual %h", $time, want.data, data_out);
            mismatches++;
          end
          if (occupancy !== want.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, occupancy);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        want = ring_answer(in_op, in_data);
        answers_due.push_back(in_typed ? in_exp : want);
      end
    end
  end

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0) stall = pick_gap(rx_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(op_e op, logic [DataW-1:0] word, logic typed, answer_t exp);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_data  <= word;
    in_typed <= typed;
    in_exp   <= exp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CountW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * RegCapacity);
    pwdata  <= ApbW'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cap_words = (v == 0) ? 5'd1 : (v > Depth) ? CountW'(Depth) : v;
    empty_ring();
    @(negedge clk);
  endtask

  initial begin
    logic [CountW-1:0] phase_caps [8];
    logic [DataW-1:0]  word;
    op_e               op;
    int                put_pct;
    int                burst;
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_op    = OpPut;
    in_data  = '0;
    in_typed = 1'b0;
    in_exp   = NoAns;
    cap_words = CapReset;
    empty_ring();
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    foreach (DirTab[i]) begin
      if (DirTab[i].cfg_on) begin
        wait_idle();
        write_capacity(DirTab[i].cfg_val);
      end
      send_word(DirTab[i].op, DirTab[i].data, DirTab[i].typed, DirTab[i].exp);
    end

    phase_caps = '{5'd16, 5'd1, 5'd17, 5'd3, CountW'($urandom_range(1, 16)),
                   CountW'($urandom_range(0, 31)), 5'd2, CountW'($urandom_range(4, 15))};
    foreach (phase_caps[p]) begin
      wait_idle();
      write_capacity(phase_caps[p]);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      burst = 0;
      put_pct = 50;
      repeat (140) begin
        if (burst == 0) begin
          burst = $urandom_range(5, 40);
          case ($urandom_range(0, 2))
            0: put_pct = 85;
            1: put_pct = 15;
            default: put_pct = 50;
          endcase
        end
        burst--;
        case ($urandom_range(0, 15))
          0: word = '0;
          1: word = '1;
          default: word = $urandom;
        endcase
        if ($urandom_range(0, 99) < put_pct) op = OpPut;
        else op = op_e'($urandom_range(1, 3));
        send_word(op, word, 1'b0, NoAns);
      end
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
